@@ sv/tbw_pkg.sv @@
// tbw_pkg: shared constants for the triangle barycentric weight block
// depends on nothing; used by every module of the block
package tbw_pkg;

	// default coordinate width and weight fraction bits
	localparam int COORD_WIDTH      = 16;
	localparam int WEIGHT_FRAC_BITS = 16;

	// result weight width, fixed
	localparam int WEIGHT_WIDTH = 32;

	// entries in the queue between classify and divide parts
	localparam int QUEUE_DEPTH = 4;

	// number of quotient bits worked out by the divider pipeline
	localparam int QUOT_BITS = 32;

endpackage

@@ sv/tbw_front.sv @@
// tbw_front: accepts beats, forms edges, cross and dot products, classifies
// degenerate triangles and hands sign/magnitude operands to the queue
// depends on tbw_pkg
module tbw_front #(
	parameter int COORD_WIDTH      = tbw_pkg::COORD_WIDTH,
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS,
	parameter int IN_TW            = ((12 * COORD_WIDTH + 7) / 8) * 8,
	parameter int DOTW             = 4 * COORD_WIDTH + 8,
	parameter int REMW             = DOTW + ((WEIGHT_FRAC_BITS > 32) ? WEIGHT_FRAC_BITS : 33)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_TW-1:0] in_data,
	output logic             push_valid,
	input  logic             push_ready,
	output logic [DOTW-1:0]  den,
	output logic [REMW-1:0]  num [3],
	output logic [2:0]       neg,
	output logic             degen
);

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int CPW = PW + 1;
	localparam int PPW = 2 * CPW;

	logic ce;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [CW-1:0]  crd [12];
	logic signed [DW-1:0]  e_s1 [3][3];
	logic signed [DW-1:0]  d_s1 [3][3];
	logic signed [DW-1:0]  opa [4][3];
	logic signed [DW-1:0]  opb [4][3];
	logic signed [PW-1:0]  pl_s2 [4][3];
	logic signed [PW-1:0]  pr_s2 [4][3];
	logic signed [CPW-1:0] cr_s3 [4][3];
	logic signed [PPW-1:0] dp_s4 [4][3];
	logic signed [DOTW-1:0] sum_s5 [4];
	logic [DOTW-1:0]       den_s6;
	logic [REMW-1:0]       num_s6 [3];
	logic [2:0]            neg_s6;
	logic                  degen_s6;

	// whole front advances unless the last stage is blocked by a full queue
	assign ce         = !v_s6 || push_ready;
	assign in_ready   = ce;
	assign push_valid = v_s6;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// unpack coordinates: point, first, second, third, each x y z
	always_comb begin
		for (int i = 0; i < 12; i++) crd[i] = in_data[i*CW +: CW];
	end

	// stage 1: edges and point differences
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				e_s1[0][k] <= DW'(crd[9+k]) - DW'(crd[6+k]);
				e_s1[1][k] <= DW'(crd[3+k]) - DW'(crd[9+k]);
				e_s1[2][k] <= DW'(crd[6+k]) - DW'(crd[3+k]);
				d_s1[0][k] <= DW'(crd[k]) - DW'(crd[3+k]);
				d_s1[1][k] <= DW'(crd[k]) - DW'(crd[6+k]);
				d_s1[2][k] <= DW'(crd[k]) - DW'(crd[9+k]);
			end
		end
	end

	// cross operand pairs: normal, then the three sub-area crosses
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			opa[0][k] = e_s1[0][k];
			opb[0][k] = e_s1[1][k];
			opa[1][k] = e_s1[0][k];
			opb[1][k] = d_s1[2][k];
			opa[2][k] = e_s1[1][k];
			opb[2][k] = d_s1[0][k];
			opa[3][k] = e_s1[2][k];
			opb[3][k] = d_s1[1][k];
		end
	end

	// stage 2: cross product partial products
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 3; k++) begin
					pl_s2[c][k] <= PW'(opa[c][(k+1)%3]) * PW'(opb[c][(k+2)%3]);
					pr_s2[c][k] <= PW'(opa[c][(k+2)%3]) * PW'(opb[c][(k+1)%3]);
				end
			end
		end
	end

	// stage 3: cross product components
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 3; k++) begin
					cr_s3[c][k] <= CPW'(pl_s2[c][k]) - CPW'(pr_s2[c][k]);
				end
			end
		end
	end

	// stage 4: dot product terms against the normal
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 3; k++) begin
					dp_s4[c][k] <= PPW'(cr_s3[c][k]) * PPW'(cr_s3[0][k]);
				end
			end
		end
	end

	// stage 5: full area and sub-area sums
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < 4; c++) begin
				sum_s5[c] <= DOTW'(dp_s4[c][0]) + DOTW'(dp_s4[c][1]) + DOTW'(dp_s4[c][2]);
			end
		end
	end

	// stage 6: classify, sign and scaled magnitude of each numerator
	always_ff @(posedge clk) begin
		if (ce) begin
			den_s6   <= DOTW'(sum_s5[0]);
			degen_s6 <= (sum_s5[0] == '0);
			for (int c = 0; c < 3; c++) begin
				neg_s6[c] <= sum_s5[c+1][DOTW-1];
				num_s6[c] <= REMW'(sum_s5[c+1][DOTW-1] ? DOTW'(-sum_s5[c+1])
					: DOTW'(sum_s5[c+1])) << WEIGHT_FRAC_BITS;
			end
		end
	end

	assign den   = den_s6;
	assign num   = num_s6;
	assign neg   = neg_s6;
	assign degen = degen_s6;

endmodule

@@ sv/tbw_queue.sv @@
// tbw_queue: short register queue between the classify and divide parts
// depends on tbw_pkg
module tbw_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tbw_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      count_q;
	logic             push, pop;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ sv/tbw_back.sv @@
// tbw_back: pipelined restoring divider, saturation and output register
// depends on tbw_pkg
module tbw_back #(
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS,
	parameter int DOTW             = 72,
	parameter int REMW             = DOTW + ((WEIGHT_FRAC_BITS > 32) ? WEIGHT_FRAC_BITS : 33)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DOTW-1:0]   den,
	input  logic [REMW-1:0]   num [3],
	input  logic [2:0]        neg,
	input  logic              degen,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [tbw_pkg::WEIGHT_WIDTH-1:0] weight [3],
	output logic              out_degen
);

	localparam int QB = tbw_pkg::QUOT_BITS;
	localparam int WW = tbw_pkg::WEIGHT_WIDTH;

	logic ce;
	logic            v_s   [QB+1];
	logic [REMW-1:0] rem_s [QB+1][3];
	logic [QB-1:0]   quo_s [QB+1][3];
	logic [REMW-1:0] den_s [QB+1];
	logic [2:0]      big_s [QB+1];
	logic [2:0]      neg_s [QB+1];
	logic            dg_s  [QB+1];
	logic            out_valid_q;
	logic [WW-1:0]   weight_q [3];
	logic            degen_q;

	// whole back part advances unless a finished beat is held at the output
	assign ce       = !out_valid_q || out_ready;
	assign in_ready = ce;

	// entry stage: overflow check against den * 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (ce) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			den_s[0] <= REMW'(den);
			neg_s[0] <= neg;
			dg_s[0]  <= degen;
			for (int c = 0; c < 3; c++) begin
				rem_s[0][c] <= num[c];
				quo_s[0][c] <= '0;
				big_s[0][c] <= (num[c] >= (REMW'(den) << QB));
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 1; i <= QB; i++) begin : g_div
		logic [REMW-1:0] sub_den;
		assign sub_den = den_s[i-1] << (QB - i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (ce) v_s[i] <= v_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				big_s[i] <= big_s[i-1];
				dg_s[i]  <= dg_s[i-1];
				for (int c = 0; c < 3; c++) begin
					if (rem_s[i-1][c] >= sub_den) begin
						rem_s[i][c] <= rem_s[i-1][c] - sub_den;
						quo_s[i][c] <= {quo_s[i-1][c][QB-2:0], 1'b1};
					end else begin
						rem_s[i][c] <= rem_s[i-1][c];
						quo_s[i][c] <= {quo_s[i-1][c][QB-2:0], 1'b0};
					end
				end
			end
		end
	end

	// output register: sign, saturation and degenerate zeroing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ce) out_valid_q <= v_s[QB];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			degen_q <= dg_s[QB];
			for (int c = 0; c < 3; c++) begin
				if (dg_s[QB]) begin
					weight_q[c] <= '0;
				end else if (neg_s[QB][c]) begin
					if (big_s[QB][c] || (quo_s[QB][c] > {1'b1, {(QB-1){1'b0}}}))
						weight_q[c] <= {1'b1, {(WW-1){1'b0}}};
					else
						weight_q[c] <= WW'(-quo_s[QB][c]);
				end else begin
					if (big_s[QB][c] || quo_s[QB][c][QB-1])
						weight_q[c] <= {1'b0, {(WW-1){1'b1}}};
					else
						weight_q[c] <= WW'(quo_s[QB][c]);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign weight    = weight_q;
	assign out_degen = degen_q;

endmodule

@@ sv/triangle_barycentric_weights.sv @@
// Barycentric weights of a 3D point against a triangle, streaming in and out.
// Takes one beat per clock unless back-pressure stalls it and returns one beat
// per input beat, in order. Each beat passes the classify pipeline, the queue,
// the divider pipeline (one quotient bit per stage) and the output register.
// A zero-area triangle returns zero weights with the degenerate flag in tuser.
// depends on tbw_pkg, tbw_front, tbw_queue, tbw_back
module triangle_barycentric_weights #(
	parameter int COORD_WIDTH      = tbw_pkg::COORD_WIDTH,
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point x y z, first x y z, second x y z, third x y z (COORD_WIDTH each)
	input  logic [((12 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// weight_first, weight_second, weight_third (32 bits each)
	output logic [3 * tbw_pkg::WEIGHT_WIDTH - 1:0] m_axis_tdata,
	// degenerate
	output logic m_axis_tuser
);

	localparam int IN_TW = ((12 * COORD_WIDTH + 7) / 8) * 8;
	localparam int DOTW  = 4 * COORD_WIDTH + 8;
	localparam int REMW  = DOTW + ((WEIGHT_FRAC_BITS > 32) ? WEIGHT_FRAC_BITS : 33);
	localparam int QW    = DOTW + 3 * REMW + 4;
	localparam int WW    = tbw_pkg::WEIGHT_WIDTH;

	logic            f_valid, f_ready, b_valid, b_ready;
	logic [DOTW-1:0] f_den, b_den;
	logic [REMW-1:0] f_num [3];
	logic [REMW-1:0] b_num [3];
	logic [2:0]      f_neg, b_neg;
	logic            f_degen, b_degen;
	logic [QW-1:0]   q_in, q_out;
	logic [WW-1:0]   weight [3];

	// classify part
	tbw_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
		.IN_TW(IN_TW),
		.DOTW(DOTW),
		.REMW(REMW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data(s_axis_tdata),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.den(f_den),
		.num(f_num),
		.neg(f_neg),
		.degen(f_degen)
	);

	// queue entry packing
	assign q_in = {f_degen, f_neg, f_num[2], f_num[1], f_num[0], f_den};
	assign {b_degen, b_neg, b_num[2], b_num[1], b_num[0], b_den} = q_out;

	tbw_queue #(
		.WIDTH(QW),
		.DEPTH(tbw_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(q_in),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(q_out)
	);

	// divide part
	tbw_back #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
		.DOTW(DOTW),
		.REMW(REMW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(b_valid),
		.in_ready(b_ready),
		.den(b_den),
		.num(b_num),
		.neg(b_neg),
		.degen(b_degen),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.weight(weight),
		.out_degen(m_axis_tuser)
	);

	assign m_axis_tdata = {weight[2], weight[1], weight[0]};

endmodule

@@ tb/triangle_barycentric_weights_test.sv @@
// Testbench for triangle_barycentric_weights: drives point and vertex beats,
// predicts weights with exact wide arithmetic and checks every output beat.
// depends on tbw_pkg and triangle_barycentric_weights
module triangle_barycentric_weights_test;

	localparam int CW = tbw_pkg::COORD_WIDTH;
	localparam int IN_BITS = ((12 * CW + 7) / 8) * 8;
	localparam int WW = tbw_pkg::WEIGHT_WIDTH;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [WW-1:0] weight_third;
		logic [WW-1:0] weight_second;
		logic [WW-1:0] weight_first;
		logic          degenerate;
	} weights_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// point x y z, first x y z, second x y z, third x y z
	logic [IN_BITS-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// weight_first, weight_second, weight_third
	logic [3*WW-1:0] m_axis_tdata;
	// degenerate
	logic m_axis_tuser;

	weights_t expected_weights[$];
	int error_count;
	int idle_cycles;
	bit hold_off_sink;
	bit sink_busy_mode;

	triangle_barycentric_weights dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// signed 3-vector helpers, wide enough for exact products
	typedef logic signed [127:0] vec_t [3];

	function automatic logic signed [255:0] dot_of(input vec_t a, input vec_t b);
		logic signed [255:0] s;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += 256'(signed'(a[i])) * 256'(signed'(b[i]));
		return s;
	endfunction

	function automatic void cross_of(input vec_t a, input vec_t b, output vec_t r);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// truncated, saturated ratio with weight fraction bits
	function automatic logic [WW-1:0] ratio_of(input logic signed [255:0] num,
			input logic signed [255:0] den);
		logic [299:0] mag_num;
		logic [299:0] mag_den;
		logic [299:0] quot;
		bit neg;
		neg = num < 0;
		mag_num = neg ? 300'(-num) : 300'(num);
		mag_den = den < 0 ? 300'(-den) : 300'(den);
		quot = (mag_num << tbw_pkg::WEIGHT_FRAC_BITS) / mag_den;
		if (neg) begin
			if (quot > 300'h8000_0000) quot = 300'h8000_0000;
			return WW'(-quot);
		end
		if (quot > 300'h7FFF_FFFF) quot = 300'h7FFF_FFFF;
		return WW'(quot);
	endfunction

	function automatic weights_t barycentric_weights(input logic [IN_BITS-1:0] beat);
		vec_t p, v1, v2, v3, e1, e2, e3, d1, d2, d3, n, t;
		logic signed [255:0] area;
		weights_t w;
		for (int i = 0; i < 3; i++) begin
			p[i]  = 128'(signed'(beat[i*CW +: CW]));
			v1[i] = 128'(signed'(beat[(3+i)*CW +: CW]));
			v2[i] = 128'(signed'(beat[(6+i)*CW +: CW]));
			v3[i] = 128'(signed'(beat[(9+i)*CW +: CW]));
			e1[i] = v3[i] - v2[i];
			e2[i] = v1[i] - v3[i];
			e3[i] = v2[i] - v1[i];
			d1[i] = p[i] - v1[i];
			d2[i] = p[i] - v2[i];
			d3[i] = p[i] - v3[i];
		end
		cross_of(e1, e2, n);
		area = dot_of(n, n);
		w = '0;
		if (area == 0) begin
			w.degenerate = 1'b1;
			return w;
		end
		cross_of(e1, d3, t);
		w.weight_first = ratio_of(dot_of(t, n), area);
		cross_of(e2, d1, t);
		w.weight_second = ratio_of(dot_of(t, n), area);
		cross_of(e3, d2, t);
		w.weight_third = ratio_of(dot_of(t, n), area);
		return w;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one beat, with an optional gap in front; valid stays high after
	// the beat until the next gap or drain
	task automatic send_triangle(input logic [IN_BITS-1:0] beat, input bit use_gap);
		int gap;
		gap = use_gap ? gap_length() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		expected_weights.push_back(barycentric_weights(beat));
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [IN_BITS-1:0] pack_coords(input logic [CW-1:0] c [12]);
		logic [IN_BITS-1:0] b;
		b = '0;
		for (int i = 0; i < 12; i++) b[i*CW +: CW] = c[i];
		return b;
	endfunction

	function automatic logic [CW-1:0] random_coord(input int spread);
		case (spread)
			0: return CW'($urandom_range(0, 31)) - CW'(16);
			1: return CW'($urandom_range(0, 4095)) - CW'(2048);
			default: return CW'($urandom);
		endcase
	endfunction

	// stop offering and wait for every expected result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_weights.size() != 0) @(posedge clk);
	endtask

	// extremes, collinear and coincident vertices, point off the plane
	task automatic test_directed();
		logic [CW-1:0] c [12];
		logic [CW-1:0] mx, mn;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		// point at each vertex of a right triangle with legs of 256
		for (int k = 0; k < 3; k++) begin
			c = '{default: '0};
			c[6] = CW'(256); c[10] = CW'(256);
			for (int i = 0; i < 3; i++) c[i] = c[3 + 3*k + i];
			send_triangle(pack_coords(c), 1'b0);
		end
		// point off the plane above the centroid
		c = '{default: '0};
		c[0] = CW'(85); c[1] = CW'(85); c[2] = CW'(1000);
		c[6] = CW'(256); c[10] = CW'(256);
		send_triangle(pack_coords(c), 1'b0);
		// coincident and collinear vertices
		c = '{default: CW'(300)};
		send_triangle(pack_coords(c), 1'b0);
		c = '{default: '0};
		c[6] = CW'(100); c[9] = CW'(200); c[1] = CW'(77);
		send_triangle(pack_coords(c), 1'b0);
		// all-extreme patterns
		c = '{default: mx};
		send_triangle(pack_coords(c), 1'b0);
		c = '{default: mn};
		send_triangle(pack_coords(c), 1'b0);
		// tiny triangle, far point: saturates both ways
		c = '{default: '0};
		c[6] = CW'(1); c[10] = CW'(1);
		c[0] = mx; c[1] = mx;
		send_triangle(pack_coords(c), 1'b0);
		c[0] = mn; c[1] = mn;
		send_triangle(pack_coords(c), 1'b0);
		c[0] = mx; c[1] = mn;
		send_triangle(pack_coords(c), 1'b0);
		// huge triangle spanning the full range
		c = '{default: '0};
		c[3] = mn; c[4] = mn; c[5] = mx;
		c[6] = mx; c[7] = mn; c[8] = mn;
		c[9] = mn; c[10] = mx; c[11] = mx;
		send_triangle(pack_coords(c), 1'b0);
		for (int i = 0; i < 3; i++) c[i] = mx;
		send_triangle(pack_coords(c), 1'b0);
		// alternating bit patterns
		c = '{default: {(CW/2){2'b10}}};
		c[4] = {(CW/2){2'b01}}; c[8] = '1; c[9] = '0;
		send_triangle(pack_coords(c), 1'b0);
		wait_drained();
	endtask

	// random triangles, mostly well-formed, some degenerate
	task automatic test_random(input int count);
		logic [CW-1:0] c [12];
		int spread, kind;
		for (int n = 0; n < count; n++) begin
			spread = $urandom_range(0, 2);
			for (int i = 0; i < 12; i++) c[i] = random_coord(spread);
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
			end else if (kind == 1) begin
				// third vertex on the line through the first two
				for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + (c[6+i] - c[3+i]);
			end else if (kind == 2) begin
				for (int i = 0; i < 3; i++) c[i] = c[3+i];
			end
			send_triangle(pack_coords(c), 1'b1);
			if (n == count / 2) wait_drained();
		end
	endtask

	// long receiver hold-off while the sender keeps offering beats
	task automatic test_backpressure();
		logic [CW-1:0] c [12];
		hold_off_sink = 1'b1;
		for (int n = 0; n < 80; n++) begin
			for (int i = 0; i < 12; i++) c[i] = random_coord(2);
			send_triangle(pack_coords(c), 1'b0);
		end
		wait_drained();
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		error_count = 0;
		hold_off_sink = 1'b0;
		sink_busy_mode = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		test_backpressure();
		sink_busy_mode = 1'b1;
		test_random(400);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS triangle_barycentric_weights");
		else
			$display("FAIL triangle_barycentric_weights");
		$finish;
	end

	// receiver ready: random gaps, plus one long counted hold-off
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_sink) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off_sink = 1'b0;
			end
			gap = sink_busy_mode ? gap_length() : ($urandom_range(0, 3) == 0 ? 1 : 0);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// output beat check
	always @(posedge clk) begin
		weights_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_weights.size() == 0) begin
				$error("output beat with no expected result");
				error_count++;
			end else begin
				exp_w = expected_weights.pop_front();
				if (m_axis_tdata[0 +: WW] !== exp_w.weight_first) begin
					$error("weight_first expected %h got %h", exp_w.weight_first,
						m_axis_tdata[0 +: WW]);
					error_count++;
				end
				if (m_axis_tdata[WW +: WW] !== exp_w.weight_second) begin
					$error("weight_second expected %h got %h", exp_w.weight_second,
						m_axis_tdata[WW +: WW]);
					error_count++;
				end
				if (m_axis_tdata[2*WW +: WW] !== exp_w.weight_third) begin
					$error("weight_third expected %h got %h", exp_w.weight_third,
						m_axis_tdata[2*WW +: WW]);
					error_count++;
				end
				if (m_axis_tuser !== exp_w.degenerate) begin
					$error("degenerate expected %b got %b", exp_w.degenerate,
						m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL triangle_barycentric_weights");
			$finish;
		end
	end

endmodule
